FILE: rtl/core/rmce_pkg.sv
// shared types and constants of the range merge and cidr expander
`default_nettype none

package rmce_pkg;

  // width of the prefix length field of a result word
  localparam int PREFIX_WIDTH = 6;

  // operation codes of an input word
  localparam logic OP_RANGE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // expansion sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DOWN = 4'b0010,
    ST_UP   = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/rmce_in_if.sv
// input channel of the range merge and cidr expander: one address range per word
`default_nettype none

interface rmce_in_if #(
  parameter int ADDR_WIDTH = 32,
  parameter int KEY_WIDTH  = 16
) ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [ADDR_WIDTH-1:0] range_begin;
  logic [ADDR_WIDTH-1:0] range_end;
  logic [KEY_WIDTH-1:0]  group_key;

  modport source (output valid, operation, range_begin, range_end, group_key,
                  input ready);
  modport sink   (input valid, operation, range_begin, range_end, group_key,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rmce_out_if.sv
// output channel of the range merge and cidr expander: one cidr block per word
`default_nettype none

interface rmce_out_if
  import rmce_pkg::*;
#(
  parameter int ADDR_WIDTH = 32,
  parameter int KEY_WIDTH  = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [ADDR_WIDTH-1:0]   block_base;
  logic [ADDR_WIDTH-1:0]   block_last_addr;
  logic [PREFIX_WIDTH-1:0] prefix_len;
  logic [KEY_WIDTH-1:0]    block_key;
  logic                    last_block;

  modport source (output valid, block_base, block_last_addr, prefix_len, block_key,
                  last_block, input ready);
  modport sink   (input valid, block_base, block_last_addr, prefix_len, block_key,
                  last_block, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/range_merge_cidr_expander.sv
// top level of the range merge and cidr expander
`default_nettype none

// Takes address ranges tagged with a group key and holds one pending range. A range
// word whose key equals the pending key and whose begin is one past the pending end
// extends the pending range (a pending range ending at the all-ones address never
// extends); a range word with begin above end is dropped; any other range word, or a
// flush word, splits the pending range into the fewest aligned cidr blocks, sent in
// ascending order with last_block on the final one, and the new range (for a range
// word) becomes pending. A word that causes no blocks leaves the sequencer in idle.
// A word that causes n blocks holds ranges.ready low while one shared add-and-compare
// unit tests one candidate block size per cycle, with the size climbing and then
// descending, and while the output side stalls. An output register lets the final
// block wait while the next word is taken. The channel interfaces
// must be built with the same ADDR_WIDTH and KEY_WIDTH as this module.
module range_merge_cidr_expander
  import rmce_pkg::*;
#(
  parameter int ADDR_WIDTH = 32,
  parameter int KEY_WIDTH  = 16
) (
  input  wire        clk,
  input  wire        rst,
  rmce_in_if.sink    ranges,
  rmce_out_if.source blocks
);

  // candidate size exponent counts 0 .. ADDR_WIDTH
  localparam int KW = $clog2(ADDR_WIDTH + 1);
  localparam logic [KW-1:0]           K_MAX = KW'(ADDR_WIDTH);
  localparam logic [PREFIX_WIDTH-1:0] AW_P  = PREFIX_WIDTH'(ADDR_WIDTH);

  state_t state;

  // pending range
  logic                  pending_valid;
  logic [ADDR_WIDTH-1:0] pending_begin;
  logic [ADDR_WIDTH-1:0] pending_end;
  logic [KEY_WIDTH-1:0]  pending_key;

  // range under expansion
  logic [ADDR_WIDTH-1:0] cur;
  logic [ADDR_WIDTH-1:0] hi;
  logic [KEY_WIDTH-1:0]  exp_key;
  logic [KW-1:0]         k;
  logic [ADDR_WIDTH-1:0] top;   // last address of the largest block found so far

  // output register
  logic                    out_valid;
  logic [ADDR_WIDTH-1:0]   out_base;
  logic [ADDR_WIDTH-1:0]   out_last;
  logic [PREFIX_WIDTH-1:0] out_prefix;
  logic [KEY_WIDTH-1:0]    out_key;
  logic                    out_lastblk;

  // shared fit test unit
  logic [KW-1:0]         cand;
  logic                  cand_ok;
  logic [ADDR_WIDTH:0]   size;
  logic [ADDR_WIDTH:0]   mask;
  logic [ADDR_WIDTH:0]   cand_top;
  logic                  fits;

  logic                  in_take;
  logic                  out_free;
  logic                  emit;
  logic                  is_flush;
  logic                  reversed;
  logic                  merge;
  logic [ADDR_WIDTH:0]   pend_succ;
  logic                  range_done;

  assign ranges.ready = (state == ST_IDLE);
  assign in_take      = ranges.valid && ranges.ready;
  assign out_free     = !out_valid || blocks.ready;
  assign emit         = (state == ST_EMIT) && out_free;

  // decode of the input word
  assign is_flush  = (ranges.operation == OP_FLUSH);
  assign reversed  = ranges.range_begin > ranges.range_end;
  // one past the pending end, with a carry bit so that an all-ones end never matches
  assign pend_succ = {1'b0, pending_end} + (ADDR_WIDTH+1)'(1);
  assign merge     = pending_valid && (ranges.group_key == pending_key) &&
                     (pend_succ == {1'b0, ranges.range_begin});

  // in the descending phase the current size is retried, when climbing the next one up
  always_comb begin
    cand    = k;
    cand_ok = 1'b1;
    if (state == ST_UP) begin
      cand    = k + KW'(1);
      cand_ok = (k != K_MAX);
    end
  end

  // block of 2^cand at cur: aligned, and its last address within the range
  assign size     = (ADDR_WIDTH+1)'(1) << cand;
  assign mask     = size - (ADDR_WIDTH+1)'(1);
  assign cand_top = {1'b0, cur} + mask;
  assign fits     = cand_ok && ((cur & mask[ADDR_WIDTH-1:0]) == '0) &&
                    (cand_top <= {1'b0, hi});

  assign range_done = (top == hi);

  // output word held until taken, a new block loads in the cycle the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (blocks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (is_flush) begin
              // flush: expand what is pending, if anything
              if (pending_valid) begin
                cur           <= pending_begin;
                hi            <= pending_end;
                exp_key       <= pending_key;
                top           <= pending_begin;
                k             <= '0;
                state         <= ST_UP;
                pending_valid <= 1'b0;
              end
            end else if (!reversed) begin
              if (merge) begin
                pending_end <= ranges.range_end;
              end else begin
                if (pending_valid) begin
                  cur     <= pending_begin;
                  hi      <= pending_end;
                  exp_key <= pending_key;
                  top     <= pending_begin;
                  k       <= '0;
                  state   <= ST_UP;
                end
                pending_valid <= 1'b1;
                pending_begin <= ranges.range_begin;
                pending_end   <= ranges.range_end;
                pending_key   <= ranges.group_key;
              end
            end
          end
        end
        ST_DOWN: begin
          // shrink until a block of 2^k fits, a single address always does
          if (fits) begin
            top   <= cand_top[ADDR_WIDTH-1:0];
            state <= ST_UP;
          end else begin
            k <= k - KW'(1);
          end
        end
        ST_UP: begin
          // grow while the next larger block still fits
          if (fits) begin
            k   <= cand;
            top <= cand_top[ADDR_WIDTH-1:0];
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_base    <= cur;
            out_last    <= top;
            out_prefix  <= AW_P - PREFIX_WIDTH'(k);
            out_key     <= exp_key;
            out_lastblk <= range_done;
            if (range_done) begin
              state <= ST_IDLE;
            end else begin
              // next block starts aligned to at least the size just sent
              cur   <= top + ADDR_WIDTH'(1);
              state <= ST_DOWN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign blocks.valid           = out_valid;
  assign blocks.block_base      = out_base;
  assign blocks.block_last_addr = out_last;
  assign blocks.prefix_len      = out_prefix;
  assign blocks.block_key       = out_key;
  assign blocks.last_block      = out_lastblk;

  // size exponent never leaves its range while expanding
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (k <= K_MAX))
    else $error("size exponent out of range");

  // the cursor never passes the end of the range being expanded
  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOWN || state == ST_UP) |-> (cur <= hi))
    else $error("expansion cursor beyond range end");

  // sending the final block of a range returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && range_done) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after final block");

  // every block sent is aligned to its own size
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_base & (out_last - out_base)) == '0))
    else $error("block base not aligned to block size");

endmodule

`default_nettype wire

FILE: tb/range_merge_cidr_expander_checker.sv
// checker of the range merge and cidr expander: predicts every cidr block and compares
module range_merge_cidr_expander_checker
  import rmce_pkg::*;
#(
  parameter int ADDR_WIDTH = 32,
  parameter int KEY_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst,
  rmce_in_if   ranges,
  rmce_out_if  blocks,
  output int   failures,
  output int   blocks_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_WIDTH-1:0] ADDR_TOP = '1;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]   base;
    logic [ADDR_WIDTH-1:0]   last_addr;
    logic [PREFIX_WIDTH-1:0] prefix;
    logic [KEY_WIDTH-1:0]    key;
    logic                    last_block;
  } cidr_block_t;

  cidr_block_t blocks_due[$];

  // the one range held back for merging
  bit                    pend_valid;
  logic [ADDR_WIDTH-1:0] pend_lo;
  logic [ADDR_WIDTH-1:0] pend_hi;
  logic [KEY_WIDTH-1:0]  pend_key;
  int                    fail_cnt = 0;

  // fewest aligned blocks covering [lo, hi], ascending
  function automatic void split_into_cidr(input logic [ADDR_WIDTH-1:0] lo,
                                          input logic [ADDR_WIDTH-1:0] hi,
                                          input logic [KEY_WIDTH-1:0] key);
    logic [63:0] cur;
    logic [63:0] top;
    logic [63:0] span;
    int          k;
    int          count;
    bit          done;
    cidr_block_t blk;
    cur   = 64'(lo);
    count = 0;
    done  = 1'b0;
    while (!done) begin
      k = ADDR_WIDTH;
      while (k > 0 && (((cur & ((64'd1 << k) - 64'd1)) != 64'd0) ||
                       (cur + (64'd1 << k) - 64'd1 > 64'(hi))))
        k--;
      span           = 64'd1 << k;
      top            = cur + span - 64'd1;
      blk.base       = cur[ADDR_WIDTH-1:0];
      blk.last_addr  = top[ADDR_WIDTH-1:0];
      blk.prefix     = PREFIX_WIDTH'(ADDR_WIDTH - k);
      blk.key        = key;
      blk.last_block = (top >= 64'(hi));
      blocks_due.insert(blocks_due.size(), blk);
      count++;
      if (top >= 64'(hi) || count >= 2 * ADDR_WIDTH)
        done = 1'b1;
      else
        cur = top + 64'd1;
    end
  endfunction

  function automatic void take_word(input logic op, input logic [ADDR_WIDTH-1:0] lo,
                                    input logic [ADDR_WIDTH-1:0] hi,
                                    input logic [KEY_WIDTH-1:0] key);
    if (op == OP_FLUSH) begin
      if (pend_valid)
        split_into_cidr(pend_lo, pend_hi, pend_key);
      pend_valid = 1'b0;
    end else if (lo > hi) begin
      // reversed range, dropped
    end else if (pend_valid && key == pend_key && pend_hi != ADDR_TOP &&
                 lo == pend_hi + ADDR_WIDTH'(1)) begin
      pend_hi = hi;
    end else begin
      if (pend_valid)
        split_into_cidr(pend_lo, pend_hi, pend_key);
      pend_valid = 1'b1;
      pend_lo    = lo;
      pend_hi    = hi;
      pend_key   = key;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // output word first, so a stray block is not hidden by one predicted at the same edge
  always @(posedge clk) begin
    cidr_block_t want;
    if (rst) begin
      blocks_due.delete();
      pend_valid = 1'b0;
    end else begin
      if (blocks.valid && blocks.ready) begin
        if (blocks_due.size() == 0) begin
          $error("unexpected cidr block %0h/%0d key %0h", blocks.block_base,
                 blocks.prefix_len, blocks.block_key);
          fail_cnt++;
        end else begin
          want = blocks_due.pop_front();
          compare_field("block_base", 64'(want.base), 64'(blocks.block_base));
          compare_field("block_last_addr", 64'(want.last_addr), 64'(blocks.block_last_addr));
          compare_field("prefix_len", 64'(want.prefix), 64'(blocks.prefix_len));
          compare_field("block_key", 64'(want.key), 64'(blocks.block_key));
          compare_field("last_block", 64'(want.last_block), 64'(blocks.last_block));
        end
      end
      if (ranges.valid && ranges.ready)
        take_word(ranges.operation, ranges.range_begin, ranges.range_end, ranges.group_key);
    end
    blocks_outstanding <= blocks_due.size();
    failures           <= fail_cnt;
  end

endmodule

FILE: tb/range_merge_cidr_expander_tb.sv
// top of the range merge and cidr expander testbench: stimulus, idling and verdict
module range_merge_cidr_expander_tb;
  import rmce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // random words after the directed ones, not counting reversed ranges
  localparam int RANDOM_WORDS = 370;
  // receiver hold-off: starts once this many words are in, lasts this many cycles
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  // cycles with no word moving on either side before the run is called dead;
  // the long hold-off plus a worst-case expansion fit well inside
  localparam int STALL_LIMIT  = 4000;
  // settling time once nothing is outstanding, about one full expansion
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;
  int   failures;
  int   blocks_outstanding;
  int   words_sent = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  rmce_in_if  ranges_ch ();
  rmce_out_if blocks_ch ();

  range_merge_cidr_expander dut (
    .clk    (clk),
    .rst    (rst),
    .ranges (ranges_ch),
    .blocks (blocks_ch)
  );

  range_merge_cidr_expander_checker block_check (
    .clk                (clk),
    .rst                (rst),
    .ranges             (ranges_ch),
    .blocks             (blocks_ch),
    .failures           (failures),
    .blocks_outstanding (blocks_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one word, with random idle cycles in front, and wait for it to be taken;
  // valid stays high into the next word unless that one idles first
  task automatic send_word(input logic op, input logic [31:0] lo, input logic [31:0] hi,
                           input logic [15:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      ranges_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ranges_ch.valid       <= 1'b1;
    ranges_ch.operation   <= op;
    ranges_ch.range_begin <= lo;
    ranges_ch.range_end   <= hi;
    ranges_ch.group_key   <= key;
    @(posedge clk);
    while (!ranges_ch.ready)
      @(posedge clk);
    words_sent <= words_sent + 1;
  endtask

  task automatic range_word(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [15:0] key);
    send_word(OP_RANGE, lo, hi, key);
  endtask

  // flush ignores the address and key fields, so they carry noise
  task automatic flush_word();
    send_word(OP_FLUSH, $urandom, $urandom, 16'($urandom));
  endtask

  // receiver: random stalls at the current rate, plus one long hold-off while the
  // sender keeps offering, so the output register and then the input back up
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    blocks_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_sent >= HOLD_AT) begin
        blocks_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        blocks_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles where no word moves on either channel
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (ranges_ch.valid && ranges_ch.ready) || (blocks_ch.valid && blocks_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] cursor;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [32:0] stop;
    logic [32:0] len;
    logic [15:0] chain_key;
    logic [15:0] key;
    int          counted;
    int          pick;

    rst                   <= 1'b1;
    ranges_ch.valid       <= 1'b0;
    ranges_ch.operation   <= OP_RANGE;
    ranges_ch.range_begin <= '0;
    ranges_ch.range_end   <= '0;
    ranges_ch.group_key   <= '0;
    send_idle_pct         <= 21;
    recv_idle_pct         <= 54;
    cursor    = $urandom;
    chain_key = '0;
    counted   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part
    flush_word();                                            // flush, nothing pending
    range_word(32'd5, 32'd4, 16'h0001);                      // reversed, nothing pending
    range_word(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000);      // whole space
    flush_word();                                            // one /0 block
    range_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);      // single top address
    range_word(32'h0000_0000, 32'h0000_0000, 16'hFFFF);      // wraps past top: no merge
    range_word(32'h0000_0001, 32'hFFFF_FFFE, 16'h1234);      // worst-case split
    flush_word();
    range_word(32'h0A00_0000, 32'h0A00_00FF, 16'h0005);
    range_word(32'h0A00_0100, 32'h0A00_01FF, 16'h0005);      // adjacent, same key: merges
    range_word(32'h0A00_0300, 32'h0A00_03FF, 16'h0005);      // gap: emits the merged /23
    range_word(32'h0A00_0400, 32'h0A00_04FF, 16'h0006);      // adjacent, other key
    range_word(32'h0A00_0500, 32'h0A00_0401, 16'h0006);      // reversed while pending
    range_word(32'h0A00_0500, 32'h0A00_05FF, 16'h0006);      // still merges after that
    flush_word();
    flush_word();                                            // second flush: nothing left
    range_word(32'd7, 32'd8, 16'h7FFF);                      // straddles alignment
    range_word(32'd3, 32'd6, 16'h8000);
    flush_word();
    range_word(32'h8000_0000, 32'hFFFF_FFFF, 16'hAAAA);
    range_word(32'h0000_0000, 32'h7FFF_FFFF, 16'hAAAA);
    flush_word();
    range_word(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h0003);
    range_word(32'h0000_0000, 32'h0000_00FF, 16'h0003);      // same key across the wrap
    flush_word();

    // random part: mostly chains of adjacent ranges under one key, so merging gets
    // exercised, with key changes, gaps, flushes, reversed and loose ranges mixed in
    while (counted < RANDOM_WORDS) begin
      if (counted >= 2 * RANDOM_WORDS / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (counted >= RANDOM_WORDS / 3) begin
        send_idle_pct <= 54;
        recv_idle_pct <= 21;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        flush_word();
        counted++;
      end else if (pick < 10) begin
        lo = $urandom;
        if (lo == 32'd0)
          lo = 32'd1;
        hi = $urandom_range(lo - 32'd1, 0);
        range_word(lo, hi, 16'($urandom));
      end else if (pick < 20) begin
        lo = $urandom;
        hi = $urandom;
        if (lo > hi) begin
          lo = hi;
          hi = ranges_ch.range_begin ^ lo ^ lo;
          hi = $urandom_range(32'hFFFF_FFFF, lo);
        end
        range_word(lo, hi, 16'($urandom));
        counted++;
      end else begin
        if (pick < 32) begin
          // new chain somewhere, now and then close to either end of the space
          case ($urandom_range(3))
            0: cursor = $urandom;
            1: cursor = 32'hFFFF_FFFF - $urandom_range(300);
            2: cursor = $urandom & 32'hFFFF_FF00;
            default: cursor = $urandom_range(300);
          endcase
          chain_key = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        end
        // mostly short ranges, some long, a few power-of-two and huge ones
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = 33'($urandom_range(64, 1));
          12, 13, 14, 15, 16: len = 33'($urandom_range(65536, 1));
          17, 18: len = 33'd1 << $urandom_range(24, 0);
          default: len = {1'b0, $urandom} + 33'd1;
        endcase
        lo = cursor;
        if ($urandom_range(11) == 0 && lo != 32'hFFFF_FFFF)
          lo = lo + 32'd1;                                   // one-address gap
        key  = ($urandom_range(9) == 0) ? chain_key ^ 16'h0001 : chain_key;
        stop = {1'b0, lo} + len - 33'd1;
        if (stop > 33'h0_FFFF_FFFF)
          stop = 33'h0_FFFF_FFFF;
        range_word(lo, stop[31:0], key);
        counted++;
        // past the top the chain carries on from zero, which must not merge
        cursor = stop[31:0] + 32'd1;
      end
    end
    flush_word();
    ranges_ch.valid <= 1'b0;

    // one edge so the count includes the blocks of the last flush
    @(posedge clk);
    while (blocks_outstanding != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
